// ===== design/wbps_pkg.sv =====
// Shared definitions for the wildcard byte pattern scanner.
// Register indexes, pattern depth and the truncation status bundle.
// No dependencies.
package wbps_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int LEN_W       = 5;
   localparam int COUNT_W     = 32;

   typedef enum logic [2:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_WILDCARD_MASK  = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_EXACT_MODE     = 3'd4,
      CSR_REGION_BYTES   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               busy;
      logic [COUNT_W-1:0] limit;
   } trunc_status_type;

endpackage

// ===== design/wbps_trunc.sv =====
// Truncation limit unit: region size rounded down to a multiple of the pattern length.
// Restoring remainder, one dividend bit per cycle.
// Depends on wbps_pkg.
module wbps_trunc import wbps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COUNT_W-1:0] dividend,
   input  logic [LEN_W-1:0]   divisor,
   output trunc_status_type   status
);

   logic                busy_ff, busy_in;
   logic [4:0]          bit_ff, bit_in;
   logic [LEN_W-2:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]  limit_ff, limit_in;
   logic [LEN_W-1:0]    trial;
   logic [LEN_W-1:0]    diff;

   always_comb begin
      trial    = {rem_ff, dividend[~bit_ff]};
      diff     = trial - divisor;
      busy_in  = busy_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      limit_in = limit_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= divisor) ? diff[LEN_W-2:0] : trial[LEN_W-2:0];
         bit_in = bit_ff + 5'd1;
         if (bit_ff == 5'd31) begin
            busy_in  = 1'b0;
            limit_in = dividend - {{(COUNT_W-LEN_W+1){1'b0}}, rem_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         bit_ff  <= '0;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
         rem_ff  <= rem_in;
      end
      limit_ff <= limit_in;
   end

   assign status.busy  = busy_ff;
   assign status.limit = limit_ff;

endmodule

// ===== design/wildcard_byte_pattern_scanner.sv =====
// Wildcard byte pattern scanner, top level.
// Takes one byte per cycle unless stalled; reports first match or not-found per block.
// Depends on wbps_pkg and wbps_trunc.
//
// The scanner accepts one byte per cycle while req_stall is low and gives its result
// through an output register backed by a one-entry skid stage; the byte window compare,
// alignment check and offset are a single registered pass. After reset, and after any
// register write, the input stalls while the truncation unit works out the region
// size rounded down to a multiple of the pattern length, one bit per cycle.
module wildcard_byte_pattern_scanner import wbps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_block_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [COUNT_W-1:0] rsp_match_offset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   logic [63:0]        pattern_low_ff, pattern_high_ff;
   logic [15:0]        wildcard_mask_ff;
   logic [LEN_W-1:0]   pattern_length_ff;
   logic               exact_mode_ff;
   logic [COUNT_W-1:0] region_bytes_ff;

   logic [LEN_W-1:0]   len_eff;
   logic [7:0]         apat_ff  [MAX_PATTERN];
   logic [7:0]         apat_in  [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] care_ff, care_in;
   logic [LEN_W-1:0]   len_ff;
   logic               use_trunc_ff, use_trunc_in;
   logic [2:0]         unit_mask_ff, unit_mask_in;

   logic [7:0]         recent_ff [MAX_PATTERN-1];
   logic [7:0]         window    [MAX_PATTERN];
   logic [COUNT_W-1:0] count_ff;
   logic               reported_ff;

   logic               out_valid_ff, out_valid_in;
   logic               out_found_ff, out_found_in;
   logic [COUNT_W-1:0] out_offset_ff, out_offset_in;
   logic               skid_valid_ff, skid_valid_in;
   logic               skid_found_ff;
   logic [COUNT_W-1:0] skid_offset_ff;

   logic               csr_write, accept, drain, push, hit;
   logic [COUNT_W:0]   seen, start_pos;
   logic [MAX_PATTERN-1:0] byte_eq;
   logic               res_found;
   logic [COUNT_W-1:0] res_offset;
   trunc_status_type   trunc;

   function automatic logic [7:0] pat_byte(input logic [LEN_W-1:0] i);
      if (i < LEN_W'(8))
         return pattern_low_ff[i[2:0]*8 +: 8];
      else if (i < LEN_W'(16))
         return pattern_high_ff[i[2:0]*8 +: 8];
      return 8'd0;
   endfunction

   function automatic logic pat_wild(input logic [LEN_W-1:0] i);
      if (exact_mode_ff || i >= LEN_W'(16))
         return 1'b0;
      return wildcard_mask_ff[i[3:0]];
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= LEN_W'(1);
         exact_mode_ff     <= 1'b0;
         region_bytes_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            CSR_WILDCARD_MASK:  wildcard_mask_ff  <= csr_data[15:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_W-1:0];
            CSR_EXACT_MODE:     exact_mode_ff     <= csr_data[0];
            CSR_REGION_BYTES:   region_bytes_ff   <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // align pattern to window slots: slot j holds pattern byte len-1-j
   always_comb begin
      logic [LEN_W-1:0] pos;
      pos = '0;
      if (pattern_length_ff == '0)
         len_eff = LEN_W'(1);
      else if (pattern_length_ff > LEN_W'(MAX_PATTERN))
         len_eff = LEN_W'(MAX_PATTERN);
      else
         len_eff = pattern_length_ff;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         apat_in[j] = 8'd0;
         care_in[j] = 1'b0;
         if (LEN_W'(j) < len_eff) begin
            pos        = len_eff - LEN_W'(1) - LEN_W'(j);
            apat_in[j] = pat_byte(pos);
            care_in[j] = !pat_wild(pos);
         end
      end
      use_trunc_in = exact_mode_ff && (len_eff >= LEN_W'(8)) && !len_eff[0];
      if (len_eff[2:0] == 3'd0)
         unit_mask_in = 3'b111;
      else if (len_eff[1:0] == 2'd0)
         unit_mask_in = 3'b011;
      else if (!len_eff[0])
         unit_mask_in = 3'b001;
      else
         unit_mask_in = 3'b000;
   end

   always_ff @(posedge clock) begin
      apat_ff      <= apat_in;
      care_ff      <= care_in;
      len_ff       <= len_eff;
      use_trunc_ff <= use_trunc_in;
      unit_mask_ff <= unit_mask_in;
   end

   wbps_trunc u_trunc (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_write),
      .dividend (region_bytes_ff),
      .divisor  (len_eff),
      .status   (trunc)
   );

   assign req_stall = trunc.busy || skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign drain     = out_valid_ff && !rsp_stall;

   always_comb begin
      window[0] = req_data_byte;
      for (int j = 1; j < MAX_PATTERN; j++)
         window[j] = recent_ff[j-1];
      for (int j = 0; j < MAX_PATTERN; j++)
         byte_eq[j] = !care_ff[j] || (window[j] == apat_ff[j]);
      seen      = {1'b0, count_ff} + (COUNT_W+1)'(1);
      start_pos = seen - (COUNT_W+1)'(len_ff);
      hit       = !reported_ff && (seen >= (COUNT_W+1)'(len_ff)) && (&byte_eq);
      if (use_trunc_ff &&
          (((start_pos[2:0] & unit_mask_ff) != 3'd0) || (seen > {1'b0, trunc.limit})))
         hit = 1'b0;
      res_found  = hit;
      res_offset = hit ? start_pos[COUNT_W-1:0] : '0;
      push       = accept && (hit || (req_block_end && !reported_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reported_ff <= 1'b0;
         for (int j = 0; j < MAX_PATTERN-1; j++)
            recent_ff[j] <= 8'd0;
      end else if (accept) begin
         if (req_block_end) begin
            count_ff    <= '0;
            reported_ff <= 1'b0;
            for (int j = 0; j < MAX_PATTERN-1; j++)
               recent_ff[j] <= 8'd0;
         end else begin
            count_ff    <= seen[COUNT_W-1:0];
            reported_ff <= reported_ff || hit;
            for (int j = 0; j < MAX_PATTERN-1; j++)
               recent_ff[j] <= window[j];
         end
      end
   end

   // output register with one-entry skid
   always_comb begin
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         out_valid_in = 1'b1;
         if (drain) begin
            out_found_in  = skid_found_ff;
            out_offset_in = skid_offset_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         out_valid_in = (out_valid_ff && !drain) || push;
         if (!out_valid_ff || drain) begin
            out_found_in  = res_found;
            out_offset_in = res_offset;
         end else if (push) begin
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
      if (!skid_valid_ff) begin
         skid_found_ff  <= res_found;
         skid_offset_ff <= res_offset;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_match_offset = out_offset_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a transfer while output register is empty");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      trunc.busy |-> req_stall)
      else $error("byte taken while truncation limit is being computed");

   a_hit_marks_block: assert property (@(posedge clock) disable iff (reset)
      (accept && hit && !req_block_end) |=> reported_ff)
      else $error("match not recorded for the rest of the block");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_offset_ff == '0))
      else $error("not-found transfer carries a non-zero offset");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (accept && reported_ff) |-> !hit)
      else $error("second match reported in one block");

endmodule
